>>> hdl/fscal_pkg.sv
// Shared widths, constants and the control bundle of the fair share core allocator.
// Used by fscal_unit, fair_share_core_allocator_top and the testbench; depends on nothing.
`default_nettype none
package fscal_pkg;

    localparam int CORE_W  = 12;
    localparam int TOTAL_W = 16;
    localparam int ACC_W   = 17;
    localparam int TIME_W  = 48;
    localparam int WIN_W   = 32;
    localparam int MASK_W  = 8;
    localparam int BIT_W   = 4;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 32'd10_000_000;
    localparam logic [CORE_W-1:0]  CORE_MAX     = 12'hFFF;
    localparam logic [ACC_W-1:0]   TOTAL_MAX    = 17'h0FFFF;
    localparam logic [ACC_W-1:0]   ACC_MAX      = 17'h1FFFF;
    localparam logic [BIT_W-1:0]   TOP_BIT      = 4'd11;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_MASK   = 1'b1;

    typedef struct packed {
        logic                clamp;
        logic [CORE_W-1:0]   lim;
        logic [ACC_W-1:0]    sat_hi;
    } t_unit_ctl;

endpackage
`default_nettype wire

>>> hdl/fair_share_core_allocator_top.sv
// Top level of the fair share core allocator: sequencer, node and connection tables.
// Depends on fscal_pkg, fscal_ram and fscal_unit.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   mode, node, conn, core count, time
//   out      source     o_out_valid / i_out_stall status, granted cores, live total
//   cfg      sink       i_cfg_we                  index, data
//
// A core request makes one pass over the node table, twelve bisection passes of the water
// level over the connection table and a ranking pass, all through the one accumulate unit
// and one read port per table. Reset clears the sequencer, mask, live total, output valid
// and table valid bits at once and loads the default window; no clearing pass.
// Input is stalled while an item is at work; a waiting result holds the sequencer in its
// last step until the previous beat has been taken.
`default_nettype none
module fair_share_core_allocator_top #(
    parameter int NODE_SLOTS = 16,
    parameter int CONN_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_in_mode,
    input  wire logic [3:0]  i_in_node_index,
    input  wire logic [2:0]  i_in_conn_index,
    input  wire logic [11:0] i_in_core_count,
    input  wire logic [47:0] i_in_now_usec,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_out_status,
    output logic [11:0]      o_out_granted_cores,
    output logic [15:0]      o_out_live_core_total,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int CORE_W  = fscal_pkg::CORE_W;
    localparam int TOTAL_W = fscal_pkg::TOTAL_W;
    localparam int ACC_W   = fscal_pkg::ACC_W;
    localparam int TIME_W  = fscal_pkg::TIME_W;
    localparam int NAW     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CAW     = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int MAXS    = (NODE_SLOTS > CONN_SLOTS) ? NODE_SLOTS : CONN_SLOTS;
    localparam int CW      = $clog2(MAXS + 1);
    localparam int NODE_DW = TIME_W + CORE_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_NODES  = 5'b00010,
        S_SEARCH = 5'b00100,
        S_RANK   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [fscal_pkg::WIN_W-1:0]  r_window;
    logic [fscal_pkg::MASK_W-1:0] r_mask;
    logic [NODE_SLOTS-1:0]        r_node_vld;
    logic [CONN_SLOTS-1:0]        r_conn_vld;
    logic [TOTAL_W-1:0]           r_live_total;

    logic [TIME_W-1:0]            r_now;
    logic [2:0]                   r_conn;
    logic                         r_is_req;
    logic                         r_status;
    logic [CW-1:0]                r_cnt;
    logic                         r_vld_q;
    logic [ACC_W-1:0]             r_acc;
    logic [ACC_W-1:0]             r_s_best;
    logic [CORE_W-1:0]            r_level;
    logic [fscal_pkg::BIT_W-1:0]  r_bit;
    logic [CORE_W-1:0]            r_need_c;

    logic                         r_out_valid;
    logic                         r_out_status;
    logic [CORE_W-1:0]            r_out_grant;
    logic [TOTAL_W-1:0]           r_out_total;

    logic                         in_acc;
    logic                         node_ok;
    logic                         conn_ok;
    logic [8:0]                   node_wide;
    logic [6:0]                   conn_wide;
    logic [NAW-1:0]               node_waddr;
    logic [CAW-1:0]               conn_waddr;
    logic                         node_we;
    logic                         conn_we;
    logic                         node_re;
    logic                         conn_re;
    logic [NODE_DW-1:0]           node_rdata;
    logic [CORE_W-1:0]            conn_rdata;
    logic [CORE_W-1:0]            node_cores;
    logic [TIME_W-1:0]            node_age;
    logic                         node_live;
    logic [CORE_W-1:0]            need;
    logic [CW-1:0]                proc_idx;
    logic                         proc;
    logic                         node_last;
    logic                         conn_last;
    logic [CORE_W-1:0]            cand;
    logic [ACC_W-1:0]             unit_acc;
    logic [CORE_W-1:0]            unit_opnd;
    fscal_pkg::t_unit_ctl         unit_ctl;
    logic [ACC_W-1:0]             unit_sum;
    logic                         out_free;
    logic [TOTAL_W-1:0]           remain;
    logic                         bump;
    logic [CORE_W-1:0]            grant;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign node_ok    = 32'(i_in_node_index) < NODE_SLOTS;
    assign conn_ok    = (32'(i_in_conn_index) < CONN_SLOTS) && r_mask[i_in_conn_index];
    assign node_wide  = {5'b0, i_in_node_index};
    assign conn_wide  = {4'b0, i_in_conn_index};
    assign node_waddr = node_wide[NAW-1:0];
    assign conn_waddr = conn_wide[CAW-1:0];
    assign node_we    = in_acc && !i_in_mode && node_ok;
    assign conn_we    = in_acc && i_in_mode && conn_ok;
    assign node_re    = (r_state == S_NODES) && (32'(r_cnt) < NODE_SLOTS);
    assign conn_re    = ((r_state == S_SEARCH) || (r_state == S_RANK)) &&
                        (32'(r_cnt) < CONN_SLOTS);

    fscal_ram #(
        .WIDTH (NODE_DW),
        .DEPTH (NODE_SLOTS)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata ({i_in_now_usec, i_in_core_count}),
        .i_re    (node_re),
        .i_raddr (r_cnt[NAW-1:0]),
        .o_rdata (node_rdata)
    );

    fscal_ram #(
        .WIDTH (CORE_W),
        .DEPTH (CONN_SLOTS)
    ) u_conn_ram (
        .i_clk   (i_clk),
        .i_we    (conn_we),
        .i_waddr (conn_waddr),
        .i_wdata (i_in_core_count),
        .i_re    (conn_re),
        .i_raddr (r_cnt[CAW-1:0]),
        .o_rdata (conn_rdata)
    );

    fscal_unit u_unit (
        .i_acc  (unit_acc),
        .i_opnd (unit_opnd),
        .i_ctl  (unit_ctl),
        .o_sum  (unit_sum)
    );

    always_comb begin
        node_cores = r_vld_q ? node_rdata[CORE_W-1:0] : '0;
        node_age   = r_now - node_rdata[NODE_DW-1:CORE_W];
        node_live  = node_age < TIME_W'(r_window);
        need       = r_vld_q ? conn_rdata : '0;
        proc       = r_cnt != '0;
        proc_idx   = r_cnt - CW'(1);
        node_last  = r_cnt == CW'(NODE_SLOTS);
        conn_last  = r_cnt == CW'(CONN_SLOTS);
        cand       = r_level | (CORE_W'(1) << r_bit);
        unit_acc   = r_acc;
        unit_opnd  = '0;
        unit_ctl   = '{clamp: 1'b0, lim: fscal_pkg::CORE_MAX, sat_hi: fscal_pkg::ACC_MAX};
        case (r_state)
            S_NODES: begin
                unit_opnd       = node_live ? node_cores : '0;
                unit_ctl.sat_hi = fscal_pkg::TOTAL_MAX;
            end
            S_SEARCH: begin
                unit_opnd     = need;
                unit_ctl.clamp = 1'b1;
                unit_ctl.lim   = cand;
            end
            S_RANK: begin
                unit_opnd = ((32'(proc_idx) < 32'(r_conn)) && (need > r_level)) ?
                            CORE_W'(1) : '0;
            end
            default: begin
                unit_opnd = '0;
            end
        endcase
    end

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        remain   = r_live_total - r_s_best[TOTAL_W-1:0];
        bump     = r_acc < ACC_W'(remain);
        grant    = '0;
        if (r_is_req && !r_status) begin
            grant = (r_need_c <= r_level) ? r_need_c : r_level + CORE_W'(bump);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_mode && conn_ok) ? S_NODES : S_DONE;
                end
            end
            S_NODES: begin
                if (node_last) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (conn_last && (r_bit == '0)) begin
                    n_state = S_RANK;
                end
            end
            S_RANK: begin
                if (conn_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= fscal_pkg::WINDOW_RESET;
            r_mask       <= '0;
            r_node_vld   <= '0;
            r_conn_vld   <= '0;
            r_live_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fscal_pkg::CFG_WINDOW: r_window <= i_cfg_data;
                    fscal_pkg::CFG_MASK:   r_mask   <= i_cfg_data[fscal_pkg::MASK_W-1:0];
                    default:               r_mask   <= r_mask;
                endcase
            end
            if (node_we) begin
                r_node_vld[node_waddr] <= 1'b1;
            end
            if (conn_we) begin
                r_conn_vld[conn_waddr] <= 1'b1;
            end
            if ((r_state == S_NODES) && node_last) begin
                r_live_total <= unit_sum[TOTAL_W-1:0];
            end
            r_out_valid <= ((r_state == S_DONE) && out_free) || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_now    <= i_in_now_usec;
                    r_conn   <= i_in_conn_index;
                    r_is_req <= i_in_mode;
                    r_status <= i_in_mode && !conn_ok;
                    r_cnt    <= '0;
                    r_acc    <= '0;
                end
            end
            S_NODES: begin
                if (node_re) begin
                    r_vld_q <= r_node_vld[r_cnt[NAW-1:0]];
                end
                if (node_last) begin
                    r_cnt    <= '0;
                    r_acc    <= '0;
                    r_bit    <= fscal_pkg::TOP_BIT;
                    r_level  <= '0;
                    r_s_best <= '0;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                    if (proc) begin
                        r_acc <= unit_sum;
                    end
                end
            end
            S_SEARCH: begin
                if (conn_re) begin
                    r_vld_q <= r_conn_vld[r_cnt[CAW-1:0]];
                end
                if (conn_last) begin
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_bit <= r_bit - fscal_pkg::BIT_W'(1);
                    if (unit_sum <= ACC_W'(r_live_total)) begin
                        r_level  <= cand;
                        r_s_best <= unit_sum;
                    end
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                    if (proc) begin
                        r_acc <= unit_sum;
                    end
                end
            end
            S_RANK: begin
                r_cnt <= r_cnt + CW'(1);
                if (conn_re) begin
                    r_vld_q <= r_conn_vld[r_cnt[CAW-1:0]];
                end
                if (proc) begin
                    r_acc <= unit_sum;
                    if (32'(proc_idx) == 32'(r_conn)) begin
                        r_need_c <= need;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_grant  <= grant;
                    r_out_total  <= r_live_total;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_in_stall            = r_state != S_IDLE;
    assign o_out_valid           = r_out_valid;
    assign o_out_status          = r_out_status;
    assign o_out_granted_cores   = r_out_grant;
    assign o_out_live_core_total = r_out_total;

    a_report_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_mode) |=> (r_state == S_DONE))
        else $error("node report did not go straight to the result step");

    a_level_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |=> (r_level >= $past(r_level)))
        else $error("water level fell during the search");

    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK) |-> (r_s_best <= ACC_W'(r_live_total)))
        else $error("accepted level hands out more cores than are live");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status) |-> (o_out_granted_cores == '0))
        else $error("refused request carries a grant");

    a_grant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (TOTAL_W'(o_out_granted_cores) <= o_out_live_core_total))
        else $error("grant exceeds the live core total");

endmodule
`default_nettype wire

>>> hdl/fscal_ram.sv
// Generic single write port RAM with one registered read port.
// Stand-alone; no package dependency.
`default_nettype none
module fscal_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/fscal_unit.sv
// Shared accumulate unit: adds an optionally clamped operand to an accumulator
// and saturates the sum. Depends on fscal_pkg.
`default_nettype none
module fscal_unit (
    input  wire logic [fscal_pkg::ACC_W-1:0]  i_acc,
    input  wire logic [fscal_pkg::CORE_W-1:0] i_opnd,
    input  wire fscal_pkg::t_unit_ctl         i_ctl,
    output logic      [fscal_pkg::ACC_W-1:0]  o_sum
);
    logic [fscal_pkg::CORE_W-1:0] term;
    logic [fscal_pkg::ACC_W:0]    sum;

    always_comb begin
        term = (i_ctl.clamp && (i_opnd > i_ctl.lim)) ? i_ctl.lim : i_opnd;
        sum  = {1'b0, i_acc} + (fscal_pkg::ACC_W + 1)'(term);
        o_sum = (sum > {1'b0, i_ctl.sat_hi}) ? i_ctl.sat_hi : sum[fscal_pkg::ACC_W-1:0];
    end

endmodule
`default_nettype wire

>>> verif/tb_fair_share_core_allocator_top.sv
// Self-checking testbench for fair_share_core_allocator_top: directed and random node reports
// and core requests, checked beat by beat against a fair share predictor held in a scoreboard.
// Depends on fscal_pkg and the fair_share_core_allocator_top RTL.
module tb_fair_share_core_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORE_W  = fscal_pkg::CORE_W;
    localparam int TOTAL_W = fscal_pkg::TOTAL_W;
    localparam int TIME_W  = fscal_pkg::TIME_W;
    localparam int WIN_W   = fscal_pkg::WIN_W;
    localparam int MASK_W  = fscal_pkg::MASK_W;

    localparam int NODES           = 16;
    localparam int CONNS           = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 600;
    localparam int TAIL_CYCLES     = 300;

    localparam logic MODE_REPORT    = 1'b0;
    localparam logic MODE_REQUEST   = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [3:0]        node;
        logic [2:0]        conn;
        logic [CORE_W-1:0] cores;
        logic [TIME_W-1:0] now;
    } t_fs_item;

    typedef struct packed {
        logic               status;
        logic [CORE_W-1:0]  granted;
        logic [TOTAL_W-1:0] total;
    } t_fs_result;

    class t_grant_scoreboard;
        logic [CORE_W-1:0]  node_cores [NODES];
        logic [TIME_W-1:0]  node_seen  [NODES];
        logic [CORE_W-1:0]  conn_need  [CONNS];
        logic [CORE_W-1:0]  conn_grant [CONNS];
        logic [TOTAL_W-1:0] live_sum;
        logic [WIN_W-1:0]   window;
        logic [MASK_W-1:0]  mask;
        t_fs_result         grants_due [$];
        int                 errors;

        function new();
            foreach (node_cores[i]) begin
                node_cores[i] = '0;
                node_seen[i]  = '0;
            end
            foreach (conn_need[i]) begin
                conn_need[i]  = '0;
                conn_grant[i] = '0;
            end
            live_sum = '0;
            window   = fscal_pkg::WINDOW_RESET;
            mask     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic idx, logic [WIN_W-1:0] data);
            if (idx == fscal_pkg::CFG_WINDOW) begin
                window = data;
            end else begin
                mask = data[MASK_W-1:0];
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void refresh_grants(logic [TIME_W-1:0] now);
            int unsigned       sum;
            int unsigned       left;
            logic [TIME_W-1:0] age;
            bit                unmet;
            sum = 0;
            for (int i = 0; i < NODES; i++) begin
                age = now - node_seen[i];
                if (age < window) begin
                    sum += node_cores[i];
                    if (sum > fscal_pkg::TOTAL_MAX) sum = fscal_pkg::TOTAL_MAX;
                end
            end
            live_sum = sum[TOTAL_W-1:0];
            foreach (conn_grant[i]) conn_grant[i] = '0;
            left = sum;
            while (left > 0) begin
                unmet = 0;
                for (int i = 0; i < CONNS; i++) begin
                    if (left > 0 && conn_grant[i] < conn_need[i]) begin
                        conn_grant[i]++;
                        left--;
                    end
                    if (conn_grant[i] < conn_need[i]) unmet = 1;
                end
                if (!unmet) break;
            end
        endfunction

        function void note_request(t_fs_item it);
            t_fs_result want;
            want.status  = STATUS_OK;
            want.granted = '0;
            if (it.mode == MODE_REPORT) begin
                node_cores[it.node] = it.cores;
                node_seen[it.node]  = it.now;
            end else if (mask[it.conn]) begin
                conn_need[it.conn] = it.cores;
                refresh_grants(it.now);
                want.granted = conn_grant[it.conn];
            end else begin
                want.status = STATUS_REFUSED;
            end
            want.total = live_sum;
            grants_due.push_back(want);
        endfunction

        task check_grant(t_fs_result got);
            t_fs_result want;
            if (grants_due.size() == 0) begin
                report($sformatf("result with nothing expected: status %0d grant %0d total %0d",
                                 got.status, got.granted, got.total));
                return;
            end
            want = grants_due.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d expected %0d", got.status, want.status));
            if (got.granted !== want.granted)
                report($sformatf("granted_cores got %0d expected %0d",
                                 got.granted, want.granted));
            if (got.total !== want.total)
                report($sformatf("live_core_total got %0d expected %0d",
                                 got.total, want.total));
        endtask

        function int pending();
            return grants_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_in_mode;
    logic [3:0]  i_in_node_index;
    logic [2:0]  i_in_conn_index;
    logic [11:0] i_in_core_count;
    logic [47:0] i_in_now_usec;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_out_status;
    logic [11:0] o_out_granted_cores;
    logic [15:0] o_out_live_core_total;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    t_grant_scoreboard sb = new();
    bit                hold_req = 0;
    logic [TIME_W-1:0] tnow;
    int unsigned       phase_step;
    logic [MASK_W-1:0] phase_mask;

    fair_share_core_allocator_top u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_in_mode             (i_in_mode),
        .i_in_node_index       (i_in_node_index),
        .i_in_conn_index       (i_in_conn_index),
        .i_in_core_count       (i_in_core_count),
        .i_in_now_usec         (i_in_now_usec),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_status          (o_out_status),
        .o_out_granted_cores   (o_out_granted_cores),
        .o_out_live_core_total (o_out_live_core_total),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb_fair_share_core_allocator_top: FAIL");
        $finish;
    end

    // Every result beat taken by the receiver is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_grant({o_out_status, o_out_granted_cores, o_out_live_core_total});
    end

    initial begin : stall_pattern
        int seg;
        int len;
        int k;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req    = 0;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                seg = $urandom_range(0, 3);
                len = $urandom_range(20, 300);
                k   = $urandom_range(2, 5);
                for (int c = 0; c < len; c++) begin
                    case (seg)
                        0: i_out_stall = 1'b0;
                        1: i_out_stall = 1'($urandom_range(0, 1));
                        2: i_out_stall = (c % k) == 0;
                        default: i_out_stall = (c < len / 2);
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    task automatic offer_item(t_fs_item it);
        bit took;
        took            = 0;
        i_in_valid      = 1'b1;
        i_in_mode       = it.mode;
        i_in_node_index = it.node;
        i_in_conn_index = it.conn;
        i_in_core_count = it.cores;
        i_in_now_usec   = it.now;
        while (!took) begin
            @(posedge i_clk);
            took = (o_in_stall == 1'b0);
            if (took) sb.note_request(it);
            @(negedge i_clk);
        end
    endtask

    task automatic offer(logic mode, logic [3:0] node, logic [2:0] conn,
                         logic [CORE_W-1:0] cores, logic [TIME_W-1:0] now);
        offer_item('{mode, node, conn, cores, now});
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(logic idx, logic [WIN_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [CORE_W-1:0] pick_cores();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return CORE_W'($urandom_range(0, 48));
        if (r < 8) return CORE_W'($urandom_range(0, 800));
        return CORE_W'($urandom_range(0, 4095));
    endfunction

    function automatic t_fs_item random_item();
        t_fs_item it;
        int       c;
        if ($urandom_range(0, 9) == 0) begin
            it.mode  = 1'($urandom);
            it.node  = 4'($urandom);
            it.conn  = 3'($urandom);
            it.cores = 12'($urandom);
            it.now   = {16'($urandom), 32'($urandom)};
            return it;
        end
        tnow     = tnow + TIME_W'($urandom_range(0, phase_step));
        it.now   = tnow;
        it.mode  = 1'($urandom_range(0, 1));
        it.node  = 4'($urandom);
        it.cores = pick_cores();
        c        = $urandom_range(0, CONNS - 1);
        if (phase_mask != '0 && $urandom_range(0, 4) != 0) begin
            while (!phase_mask[c]) c = $urandom_range(0, CONNS - 1);
        end
        it.conn = 3'(c);
        return it;
    endfunction

    initial begin : stimulus
        int                burst;
        int                gap;
        logic [WIN_W-1:0]  win;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_mode       = MODE_REPORT;
        i_in_node_index = '0;
        i_in_conn_index = '0;
        i_in_core_count = '0;
        i_in_now_usec   = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = fscal_pkg::CFG_WINDOW;
        i_cfg_data      = '0;
        tnow            = '0;
        phase_step      = 1;
        phase_mask      = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        offer(MODE_REQUEST, 4'd0, 3'd0, 12'd5, 48'd0);
        settle();
        set_reg(fscal_pkg::CFG_MASK, 32'h0000_00FF);
        offer(MODE_REPORT, 4'd0, 3'd0, 12'd4095, 48'd0);
        offer(MODE_REPORT, 4'd15, 3'd7, 12'd4095, 48'd100);
        offer(MODE_REQUEST, 4'd0, 3'd7, 12'd4095, 48'd200);
        offer(MODE_REQUEST, 4'd15, 3'd0, 12'd4095, 48'd300);
        offer(MODE_REQUEST, 4'd5, 3'd3, 12'd0, 48'd400);
        offer(MODE_REPORT, 4'd5, 3'd2, 12'd0, 48'hFFFF_FFFF_FFFF);
        offer(MODE_REQUEST, 4'd10, 3'd1, 12'd10, 48'hFFFF_FFFF_FFFF);
        offer(MODE_REQUEST, 4'd3, 3'd2, 12'd1, 48'd50);
        offer(MODE_REPORT, 4'd3, 3'd5, 12'd2048, 48'd60);
        offer(MODE_REPORT, 4'd12, 3'd4, 12'h555, 48'd61);
        offer(MODE_REQUEST, 4'd6, 3'd5, 12'hAAA, 48'd70);
        offer(MODE_REPORT, 4'd9, 3'd6, 12'h007, 48'h8000_0000_0000);
        settle();
        set_reg(fscal_pkg::CFG_MASK, 32'h0000_0008);
        offer(MODE_REQUEST, 4'd0, 3'd0, 12'd7, 48'd80);
        offer(MODE_REQUEST, 4'd0, 3'd3, 12'd100, 48'd90);
        settle();
        set_reg(fscal_pkg::CFG_WINDOW, 32'd0);
        offer(MODE_REQUEST, 4'd0, 3'd3, 12'd100, 48'd95);
        settle();
        set_reg(fscal_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
        offer(MODE_REQUEST, 4'd0, 3'd3, 12'd4095, 48'd96);

        burst = 0;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    win        = '0;
                    phase_step = 50;
                    phase_mask = 8'hFF;
                end
                1: begin
                    win        = 32'hFFFF_FFFF;
                    phase_step = 1_000_000;
                    phase_mask = 8'hFF;
                end
                2: begin
                    win        = fscal_pkg::WINDOW_RESET;
                    phase_step = 1_000_000;
                    phase_mask = MASK_W'($urandom);
                    tnow       = 48'hFFFF_FFFF_FFFF - 48'd60_000_000;
                end
                default: begin
                    win        = WIN_W'($urandom_range(16, 200_000));
                    phase_step = win / 6 + 1;
                    phase_mask = MASK_W'($urandom);
                end
            endcase
            set_reg(fscal_pkg::CFG_WINDOW, win);
            set_reg(fscal_pkg::CFG_MASK, {{(WIN_W - MASK_W){1'b0}}, phase_mask});
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 3 && n == 120) hold_req = 1;
                offer_item(random_item());
                if (burst > 0) begin
                    burst--;
                end else begin
                    i_in_valid = 1'b0;
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 160)
                                                      : $urandom_range(1, 6);
                    repeat (gap) @(negedge i_clk);
                    burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(0, 10);
                end
            end
        end

        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_fair_share_core_allocator_top: PASS");
        end else begin
            $display("tb_fair_share_core_allocator_top: FAIL");
        end
        $finish;
    end

endmodule
